// File: rtl/assert_macros.svh
// ----------------------------------------------------------------------------
// assert_macros.svh
// Concurrent assertion helpers, included by rx_frame_classifier.
// ----------------------------------------------------------------------------
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// Check a property on every clock edge outside reset
`define ASSERT_ON_CLK(lbl, clk, rst_n, prop, msg) \
    lbl: assert property (@(posedge clk) disable iff (!rst_n) prop) else $error(msg);

// Check a property on every clock edge, reset included
`define ASSERT_ALWAYS(lbl, clk, prop, msg) \
    lbl: assert property (@(posedge clk) prop) else $error(msg);

`endif

// File: rtl/rfc_pkg.sv
// ----------------------------------------------------------------------------
// rfc_pkg
// Types, constants and the verdict function of the received frame classifier.
// ----------------------------------------------------------------------------
package rfc_pkg;

    localparam int MAX_FRAME = 64;
    localparam int MIN_FRAME = 14;
    localparam int COUNT_W   = 7;
    localparam int CFG_IDX_W = 3;
    localparam int CFG_DATA_W = 32;

    localparam logic [7:0] ACK_OK_STATUS = 8'h01;

    // Byte positions inside a frame
    localparam logic [COUNT_W-1:0] POS_VERSION = COUNT_W'(1);
    localparam logic [COUNT_W-1:0] POS_COMMAND = COUNT_W'(2);
    localparam logic [COUNT_W-1:0] POS_HASH_LO = COUNT_W'(3);
    localparam logic [COUNT_W-1:0] POS_HASH_HI = COUNT_W'(6);
    localparam logic [COUNT_W-1:0] POS_CHILD_LO = COUNT_W'(7);
    localparam logic [COUNT_W-1:0] POS_CHILD_HI = COUNT_W'(10);
    localparam logic [COUNT_W-1:0] POS_SLOT = COUNT_W'(11);
    localparam logic [COUNT_W-1:0] COUNT_SAT = COUNT_W'(MAX_FRAME + 1);
    localparam logic [COUNT_W-1:0] LEN_MAX = COUNT_W'(MAX_FRAME);
    localparam logic [COUNT_W-1:0] LEN_MIN = COUNT_W'(MIN_FRAME);

    typedef enum logic [3:0] {
        ST_ACK_OK     = 4'd0,
        ST_PAIR_ME    = 4'd1,
        ST_SHORT      = 4'd2,
        ST_BAD_HEADER = 4'd3,
        ST_OTHER_CMD  = 4'd4,
        ST_BAD_SUM    = 4'd5,
        ST_ACK_MISS   = 4'd6,
        ST_PAIR_OTHER = 4'd7,
        ST_LONG       = 4'd8
    } t_status;

    typedef enum logic [CFG_IDX_W-1:0] {
        CFG_HEADER  = 3'd0,
        CFG_VERSION = 3'd1,
        CFG_ACK     = 3'd2,
        CFG_PAIR    = 3'd3,
        CFG_PARENT  = 3'd4,
        CFG_DEVICE  = 3'd5
    } t_cfg_idx;

    typedef struct packed {
        logic [7:0]  header_value;
        logic [7:0]  version_value;
        logic [7:0]  ack_code;
        logic [7:0]  pair_code;
        logic [31:0] paired_parent_hash;
        logic [31:0] own_device_id;
    } t_cfg;

    // One byte handed to the frame tracker
    typedef struct packed {
        logic       valid;
        logic [7:0] rx_byte;
        logic       frame_end;
    } t_step;

    // Frame state after the current byte; xor_before and prev hold the XOR and last byte from before it
    typedef struct packed {
        logic [COUNT_W-1:0] count;
        logic               prefix_bad;
        logic [7:0]         command;
        logic [31:0]        hash;
        logic [31:0]        child;
        logic [7:0]         slot;
        logic [7:0]         xor_before;
        logic [7:0]         prev;
    } t_frame;

    typedef struct packed {
        t_status            status;
        logic [31:0]        hash;
        logic [7:0]         slot;
        logic [COUNT_W-1:0] length;
    } t_result;

    // Verdict for a finished frame, checks in priority order
    function automatic t_status classify(input t_frame f, input t_cfg c);
        t_status s;
        if (f.count < LEN_MIN) begin
            s = ST_SHORT;
        end else if (f.count > LEN_MAX) begin
            s = ST_LONG;
        end else if (f.prefix_bad) begin
            s = ST_BAD_HEADER;
        end else if (f.command != c.ack_code && f.command != c.pair_code) begin
            s = ST_OTHER_CMD;
        end else if ((f.xor_before ^ f.prev) != f.prev) begin
            s = ST_BAD_SUM;
        end else if (f.command == c.ack_code) begin
            s = (f.hash == c.paired_parent_hash && f.child == c.own_device_id &&
                 f.slot == ACK_OK_STATUS) ? ST_ACK_OK : ST_ACK_MISS;
        end else begin
            s = (f.child == c.own_device_id) ? ST_PAIR_ME : ST_PAIR_OTHER;
        end
        return s;
    endfunction

endpackage

// File: rtl/rfc_in_if.sv
// ----------------------------------------------------------------------------
// rfc_in_if
// Byte stream channel into the classifier.
// ----------------------------------------------------------------------------
interface rfc_in_if;
    logic       valid;
    logic       ready;
    logic [7:0] rx_byte;
    logic       frame_end;

    modport source (output valid, output rx_byte, output frame_end, input ready);
    modport sink   (input valid, input rx_byte, input frame_end, output ready);
endinterface

// File: rtl/rfc_out_if.sv
// ----------------------------------------------------------------------------
// rfc_out_if
// Verdict channel out of the classifier.
// ----------------------------------------------------------------------------
interface rfc_out_if
    import rfc_pkg::*;
;
    logic               valid;
    logic               ready;
    logic [3:0]         frame_status;
    logic [31:0]        parent_hash;
    logic [7:0]         logical_slot;
    logic [COUNT_W-1:0] frame_length;

    modport source (output valid, output frame_status, output parent_hash,
                    output logical_slot, output frame_length, input ready);
    modport sink   (input valid, input frame_status, input parent_hash,
                    input logical_slot, input frame_length, output ready);
endinterface

// File: rtl/rfc_track.sv
// ----------------------------------------------------------------------------
// rfc_track
// Per-frame state: byte count, running XOR, last byte, prefix check and
// captures of command, hash, child id and slot byte.
// ----------------------------------------------------------------------------
module rfc_track
    import rfc_pkg::*;
(
    input  logic   i_clk,
    input  logic   i_rst_n,
    input  t_cfg   i_cfg,
    input  t_step  i_step,
    output t_frame o_frame
);

    logic [COUNT_W-1:0] r_count, n_count;
    logic [7:0]         r_xor, n_xor;
    logic [7:0]         r_last;
    logic               r_prefix_bad, n_prefix_bad;
    logic [7:0]         r_cmd, n_cmd;
    logic [31:0]        r_hash, n_hash;
    logic [31:0]        r_child, n_child;
    logic [7:0]         r_slot, n_slot;

    // Fold the incoming byte into the frame state
    always_comb begin
        n_count      = (r_count < COUNT_SAT) ? r_count + COUNT_W'(1) : r_count;
        n_xor        = r_xor;
        n_prefix_bad = r_prefix_bad;
        n_cmd        = r_cmd;
        n_hash       = r_hash;
        n_child      = r_child;
        n_slot       = r_slot;
        if (r_count == '0) begin
            if (i_step.rx_byte != i_cfg.header_value) n_prefix_bad = 1'b1;
        end else begin
            n_xor = r_xor ^ i_step.rx_byte;
            if (r_count == POS_VERSION && i_step.rx_byte != i_cfg.version_value)
                n_prefix_bad = 1'b1;
            if (r_count == POS_COMMAND) n_cmd = i_step.rx_byte;
            if (r_count inside {[POS_HASH_LO:POS_HASH_HI]})
                n_hash = {r_hash[23:0], i_step.rx_byte};
            if (r_count inside {[POS_CHILD_LO:POS_CHILD_HI]})
                n_child = {r_child[23:0], i_step.rx_byte};
            if (r_count == POS_SLOT) n_slot = i_step.rx_byte;
        end
    end

    // Present the updated state for the verdict
    always_comb begin
        o_frame.count      = n_count;
        o_frame.prefix_bad = n_prefix_bad;
        o_frame.command    = n_cmd;
        o_frame.hash       = n_hash;
        o_frame.child      = n_child;
        o_frame.slot       = n_slot;
        o_frame.xor_before = r_xor;
        o_frame.prev       = r_last;
    end

    // Advance on each byte, clear after the final one
    always_ff @(posedge i_clk) begin
        if (!i_rst_n || (i_step.valid && i_step.frame_end)) begin
            r_count      <= '0;
            r_xor        <= '0;
            r_last       <= '0;
            r_prefix_bad <= 1'b0;
            r_cmd        <= '0;
            r_hash       <= '0;
            r_child      <= '0;
            r_slot       <= '0;
        end else if (i_step.valid) begin
            r_count      <= n_count;
            r_xor        <= n_xor;
            r_last       <= i_step.rx_byte;
            r_prefix_bad <= n_prefix_bad;
            r_cmd        <= n_cmd;
            r_hash       <= n_hash;
            r_child      <= n_child;
            r_slot       <= n_slot;
        end
    end

endmodule

// File: rtl/rx_frame_classifier.sv
// ----------------------------------------------------------------------------
// rx_frame_classifier
// Classifies a received radio frame streamed one byte per transfer.
// ----------------------------------------------------------------------------
// Path: a final byte passes the input register, then the result register,
//   before its verdict is shown.
// Throughput: one byte per cycle; the result register frees the input side
//   whenever the held verdict is taken or no verdict is pending.
// Reset: synchronous, active low; clears the frame state and the pipeline
//   valids and loads the configuration registers with their defaults.
module rx_frame_classifier
    import rfc_pkg::*;
(
    input  logic                  i_clk,
    input  logic                  i_rst_n,
    input  logic                  i_cfg_we,
    input  logic [CFG_IDX_W-1:0]  i_cfg_index,
    input  logic [CFG_DATA_W-1:0] i_cfg_data,
    rfc_in_if.sink                i_rx,
    rfc_out_if.source             o_res
);

    `include "assert_macros.svh"

    t_cfg    r_cfg;
    logic    r_s1_valid;
    logic    [7:0] r_s1_byte;
    logic    r_s1_end;
    logic    r_out_valid;
    t_result r_out, n_out;
    logic    out_free;
    logic    s1_go;
    t_step   step;
    t_frame  frame;

    // Configuration writes
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_cfg.header_value       <= 8'hA5;
            r_cfg.version_value      <= 8'h03;
            r_cfg.ack_code           <= 8'h12;
            r_cfg.pair_code          <= 8'h10;
            r_cfg.paired_parent_hash <= '0;
            r_cfg.own_device_id      <= '0;
        end else if (i_cfg_we) begin
            case (t_cfg_idx'(i_cfg_index))
                CFG_HEADER:  r_cfg.header_value       <= i_cfg_data[7:0];
                CFG_VERSION: r_cfg.version_value      <= i_cfg_data[7:0];
                CFG_ACK:     r_cfg.ack_code           <= i_cfg_data[7:0];
                CFG_PAIR:    r_cfg.pair_code          <= i_cfg_data[7:0];
                CFG_PARENT:  r_cfg.paired_parent_hash <= i_cfg_data[31:0];
                CFG_DEVICE:  r_cfg.own_device_id      <= i_cfg_data[31:0];
                default: begin
                end
            endcase
        end
    end

    // Handshake: a final byte waits for a free result register
    assign out_free   = !r_out_valid || o_res.ready;
    assign s1_go      = r_s1_valid && (!r_s1_end || out_free);
    assign i_rx.ready = !r_s1_valid || s1_go;

    // Input register
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_s1_valid <= 1'b0;
        end else if (i_rx.ready) begin
            r_s1_valid <= i_rx.valid;
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_rx.valid && i_rx.ready) begin
            r_s1_byte <= i_rx.rx_byte;
            r_s1_end  <= i_rx.frame_end;
        end
    end

    assign step.valid     = s1_go;
    assign step.rx_byte   = r_s1_byte;
    assign step.frame_end = r_s1_end;

    rfc_track u_track (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_cfg   (r_cfg),
        .i_step  (step),
        .o_frame (frame)
    );

    // Build the verdict of the frame
    always_comb begin
        n_out.status = classify(frame, r_cfg);
        n_out.hash   = frame.hash;
        n_out.slot   = frame.slot;
        n_out.length = (frame.count > LEN_MAX) ? LEN_MAX : frame.count;
    end

    // Result register
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_out_valid <= 1'b0;
        end else if (s1_go && r_s1_end) begin
            r_out_valid <= 1'b1;
        end else if (o_res.ready) begin
            r_out_valid <= 1'b0;
        end
    end

    always_ff @(posedge i_clk) begin
        if (s1_go && r_s1_end) begin
            r_out <= n_out;
        end
    end

    assign o_res.valid        = r_out_valid;
    assign o_res.frame_status = r_out.status;
    assign o_res.parent_hash  = r_out.hash;
    assign o_res.logical_slot = r_out.slot;
    assign o_res.frame_length = r_out.length;

    `ASSERT_ON_CLK(a_end_gives_result, i_clk, i_rst_n, s1_go && r_s1_end |=> r_out_valid, "final byte gave no verdict")
    `ASSERT_ON_CLK(a_len_bound, i_clk, i_rst_n, r_out_valid |-> r_out.length <= LEN_MAX, "frame length above maximum")
    `ASSERT_ON_CLK(a_short_match, i_clk, i_rst_n, r_out_valid |-> ((r_out.length < LEN_MIN) == (r_out.status == ST_SHORT)), "short verdict and length disagree")
    `ASSERT_ON_CLK(a_ack_slot, i_clk, i_rst_n, r_out_valid && r_out.status == ST_ACK_OK |-> r_out.slot == ACK_OK_STATUS, "ack ok without status one")

endmodule
